// ===== design/fbm_pkg.sv =====
package fbm_pkg;

  localparam int unsigned ADDR_W = 24;
  localparam int unsigned SIZE_W = 25;
  // bitmap memory word: 64 frames per entry
  localparam int unsigned WORD_W = 64;
  localparam int unsigned BIT_W  = 6;
  // offset + size + block - 1 stays below 2^26
  localparam int unsigned DIV_W  = 26;

  typedef enum logic [1:0] {
    ACT_RELEASE = 2'd0,
    ACT_RESERVE = 2'd1,
    ACT_ALLOC   = 2'd2,
    ACT_FREE    = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] base_address;
    logic [SIZE_W-1:0] region_size;
  } fba_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] frame_address;
    logic              out_of_memory;
  } fba_out_t;

  typedef enum logic {
    MAP_FILL = 1'b0,
    MAP_SCAN = 1'b1
  } map_op_t;

  typedef struct packed {
    logic    start;
    map_op_t op;
    logic    set;
  } map_cmd_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic oom;
  } map_rsp_t;

endpackage

// ===== design/fbm_div.sv =====
module fbm_div #(
  parameter int unsigned DIVISOR = 4096,
  parameter int unsigned DW      = 26
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [DW-1:0]                dividend,
  output logic                         done,
  output logic [DW-1:0]                quotient,
  output logic [$clog2(DIVISOR)-1:0]   remainder
);

  localparam int unsigned RW = $clog2(DIVISOR);

  logic [DW-1:0] quo_r, quo_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic          done_r, done_nxt;

  // divisor is a power of two: quotient is a shift, remainder a mask
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    done_nxt = start;
    if (start) begin
      quo_nxt = dividend >> RW;
      rem_nxt = dividend[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== design/fbm_map.sv =====
module fbm_map #(
  parameter int unsigned NUM_FRAMES = 4096,
  parameter int unsigned FW         = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fbm_pkg::map_cmd_t cmd,
  input  logic [FW-1:0]     lo_frame,
  input  logic [FW-1:0]     hi_frame,
  output fbm_pkg::map_rsp_t rsp,
  output logic [FW-1:0]     found_frame
);

  import fbm_pkg::*;

  localparam int unsigned DEPTH = (NUM_FRAMES + WORD_W - 1) / WORD_W;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    M_CLR  = 3'b001,
    M_IDLE = 3'b010,
    M_RUN  = 3'b100
  } mstate_t;

  mstate_t           state_r, state_nxt;
  map_op_t           op_r, op_nxt;
  logic              set_r, set_nxt;
  logic [AW-1:0]     lo_word_r, lo_word_nxt;
  logic [AW-1:0]     end_r, end_nxt;
  logic [BIT_W-1:0]  lo_bit_r, lo_bit_nxt;
  logic [BIT_W-1:0]  hi_bit_r, hi_bit_nxt;
  logic              iss_on_r, iss_on_nxt;
  logic [AW-1:0]     iss_addr_r, iss_addr_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]     tag_r, tag_nxt;
  logic [WORD_W-1:0] rdata_r;
  logic              done_r, done_nxt;
  logic              oom_r, oom_nxt;
  logic [FW-1:0]     found_r, found_nxt;

  logic              rd_en;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;

  logic [WORD_W-1:0] avail;
  logic              any_free;
  logic [BIT_W-1:0]  pbit;
  logic [WORD_W-1:0] lo_mask, hi_mask, fmask, merged, onehot;

  logic [WORD_W-1:0] mem [DEPTH];

  // word datapath: lowest free bit for scans, range mask for fills
  always_comb begin
    avail = ~rdata_r;
    if (tag_r == '0) begin
      avail[0] = 1'b0;          // frame 0 is never handed out
    end
    any_free = |avail;
    pbit     = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (avail[i]) begin
        pbit = BIT_W'(i);
      end
    end
    onehot  = WORD_W'(1) << pbit;
    lo_mask = (tag_r == lo_word_r) ? ({WORD_W{1'b1}} << lo_bit_r) : {WORD_W{1'b1}};
    hi_mask = (tag_r == end_r) ? ({WORD_W{1'b1}} >> ~hi_bit_r) : {WORD_W{1'b1}};
    fmask   = lo_mask & hi_mask;
    merged  = set_r ? (rdata_r | fmask) : (rdata_r & ~fmask);
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    set_nxt      = set_r;
    lo_word_nxt  = lo_word_r;
    end_nxt      = end_r;
    lo_bit_nxt   = lo_bit_r;
    hi_bit_nxt   = hi_bit_r;
    iss_on_nxt   = iss_on_r;
    iss_addr_nxt = iss_addr_r;
    rd_vld_nxt   = 1'b0;
    tag_nxt      = tag_r;
    done_nxt     = 1'b0;
    oom_nxt      = oom_r;
    found_nxt    = found_r;
    rd_en        = 1'b0;
    we           = 1'b0;
    waddr        = tag_r;
    wdata        = merged;
    unique case (state_r)
      M_CLR: begin
        we    = 1'b1;
        waddr = iss_addr_r;
        wdata = {WORD_W{1'b1}};
        if (iss_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = M_IDLE;
        end else begin
          iss_addr_nxt = iss_addr_r + 1'b1;
        end
      end
      M_IDLE: begin
        if (cmd.start) begin
          op_nxt      = cmd.op;
          set_nxt     = cmd.set;
          lo_word_nxt = AW'(lo_frame >> BIT_W);
          lo_bit_nxt  = lo_frame[BIT_W-1:0];
          hi_bit_nxt  = hi_frame[BIT_W-1:0];
          iss_on_nxt  = 1'b1;
          if (cmd.op == MAP_SCAN) begin
            iss_addr_nxt = '0;
            end_nxt      = AW'(DEPTH - 1);
          end else begin
            iss_addr_nxt = AW'(lo_frame >> BIT_W);
            end_nxt      = AW'(hi_frame >> BIT_W);
          end
          state_nxt = M_RUN;
        end
      end
      M_RUN: begin
        // issue one read per cycle; write back the word returned last cycle
        if (iss_on_r) begin
          rd_en      = 1'b1;
          rd_vld_nxt = 1'b1;
          tag_nxt    = iss_addr_r;
          if (iss_addr_r == end_r) begin
            iss_on_nxt = 1'b0;
          end else begin
            iss_addr_nxt = iss_addr_r + 1'b1;
          end
        end
        if (rd_vld_r) begin
          if (op_r == MAP_SCAN) begin
            if (any_free) begin
              we         = 1'b1;
              wdata      = rdata_r | onehot;
              done_nxt   = 1'b1;
              oom_nxt    = 1'b0;
              found_nxt  = FW'({tag_r, pbit});
              iss_on_nxt = 1'b0;
              rd_vld_nxt = 1'b0;
              state_nxt  = M_IDLE;
            end else if (tag_r == end_r) begin
              done_nxt  = 1'b1;
              oom_nxt   = 1'b1;
              state_nxt = M_IDLE;
            end
          end else begin
            we    = 1'b1;
            wdata = merged;
            if (tag_r == end_r) begin
              done_nxt  = 1'b1;
              oom_nxt   = 1'b0;
              state_nxt = M_IDLE;
            end
          end
        end
      end
      default: state_nxt = M_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[iss_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= M_CLR;
      iss_addr_r <= '0;
      iss_on_r   <= 1'b0;
      rd_vld_r   <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      iss_addr_r <= iss_addr_nxt;
      iss_on_r   <= iss_on_nxt;
      rd_vld_r   <= rd_vld_nxt;
      done_r     <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    set_r     <= set_nxt;
    lo_word_r <= lo_word_nxt;
    end_r     <= end_nxt;
    lo_bit_r  <= lo_bit_nxt;
    hi_bit_r  <= hi_bit_nxt;
    tag_r     <= tag_nxt;
    oom_r     <= oom_nxt;
    found_r   <= found_nxt;
  end

  assign rsp.idle    = (state_r == M_IDLE);
  assign rsp.done    = done_r;
  assign rsp.oom     = oom_r;
  assign found_frame = found_r;

`ifndef SYNTH
  a_no_rw_same_word: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && we) |-> (iss_addr_r != waddr))
    else $error("read and write hit the same bitmap word");

  a_done_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(state_r == M_RUN))
    else $error("map done without a running sweep");

  a_never_frame0: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && !oom_r && op_r == MAP_SCAN) |-> (found_r != '0))
    else $error("scan returned frame 0");

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> (state_r == M_IDLE))
    else $error("map command while busy");
`endif

endmodule

// ===== design/frame_bitmap_allocator_unit.sv =====
// Bitmap frame allocator: one bit per physical frame (1 = used), held in a
// 64-frame-per-word synchronous RAM. After reset the block runs a clearing
// pass that writes every word to all-used, with in_ready low. Each input
// word carries one action and gives exactly one output word. Allocate scans
// the bitmap one word per cycle from word 0. BLOCK_BYTES must be a power of
// two: free, release and reserve split the byte address (and the size) into
// block numbers with a registered shift and mask. A free whose frame lies
// past the store, and a release or reserve whose clipped region is empty,
// skip the bitmap. Region sweeps are clipped at the end of the store; frame
// 0 is never handed out. A finished output word waits in the output register
// while the next input word is taken.
module frame_bitmap_allocator_unit #(
  parameter int unsigned NUM_FRAMES  = 4096,
  parameter int unsigned BLOCK_BYTES = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  fbm_pkg::fba_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fbm_pkg::fba_out_t out_data
);

  import fbm_pkg::*;

  // frame index width, never narrower than the in-word bit index
  localparam int unsigned FW = ($clog2(NUM_FRAMES) > BIT_W) ? $clog2(NUM_FRAMES) : BIT_W;
  localparam int unsigned RW = $clog2(BLOCK_BYTES);
  localparam int unsigned EW = DIV_W + 1;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DIV_BASE = 7'b0000010,
    S_DIV_CNT  = 7'b0000100,
    S_RANGE    = 7'b0001000,
    S_MAP      = 7'b0010000,
    S_MUL      = 7'b0100000,
    S_RESP     = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  action_t           act_r, act_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [DIV_W-1:0]  first_r, first_nxt;   // first block number
  logic [DIV_W-1:0]  count_r, count_nxt;   // blocks to touch
  logic [FW-1:0]     frame_r, frame_nxt;
  logic              oom_r, oom_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  fba_out_t          out_data_r, out_data_nxt;

  // divider hookup
  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic              div_done;
  logic [DIV_W-1:0]  div_q;
  logic [RW-1:0]     div_r;

  // bitmap engine hookup
  map_cmd_t          map_cmd;
  map_rsp_t          map_rsp;
  logic [FW-1:0]     map_frame;
  logic [FW-1:0]     lo_frame, hi_frame;

  // range clipping
  logic [EW-1:0]     last_blk;
  logic              in_store;
  logic              nonempty;

  fbm_div #(
    .DIVISOR (BLOCK_BYTES),
    .DW      (DIV_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  fbm_map #(
    .NUM_FRAMES (NUM_FRAMES),
    .FW         (FW)
  ) u_map (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (map_cmd),
    .lo_frame    (lo_frame),
    .hi_frame    (hi_frame),
    .rsp         (map_rsp),
    .found_frame (map_frame)
  );

  // Blocks [first, first+count) clipped to the store; the last block is
  // only meaningful when count is nonzero.
  always_comb begin
    last_blk = EW'(first_r) + EW'(count_r) - 1'b1;
    in_store = (first_r < DIV_W'(NUM_FRAMES));
    nonempty = in_store && (count_r != '0);
    lo_frame = FW'(first_r);
    hi_frame = (last_blk > EW'(NUM_FRAMES - 1)) ? FW'(NUM_FRAMES - 1) : FW'(last_blk);
  end

  assign in_ready = (state_r == S_IDLE) && map_rsp.idle;

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    size_nxt      = size_r;
    first_nxt     = first_r;
    count_nxt     = count_r;
    frame_nxt     = frame_r;
    oom_nxt       = oom_r;
    addr_nxt      = addr_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    div_start     = 1'b0;
    div_dividend  = DIV_W'(in_data.base_address);
    map_cmd       = '{start: 1'b0, op: MAP_FILL, set: 1'b0};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          act_nxt  = action_t'(in_data.action);
          size_nxt = in_data.region_size;
          addr_nxt = '0;
          oom_nxt  = 1'b0;
          if (in_data.action == ACT_ALLOC) begin
            map_cmd   = '{start: 1'b1, op: MAP_SCAN, set: 1'b1};
            state_nxt = S_MAP;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV_BASE;
          end
        end
      end
      S_DIV_BASE: begin
        if (div_done) begin
          first_nxt = div_q;
          if (act_r == ACT_FREE) begin
            count_nxt = DIV_W'(1);
            state_nxt = S_RANGE;
          end else begin
            // release: whole blocks only; reserve: every block touched
            div_start = 1'b1;
            if (act_r == ACT_RELEASE) begin
              div_dividend = DIV_W'(size_r);
            end else begin
              div_dividend = DIV_W'(div_r) + DIV_W'(size_r) + DIV_W'(BLOCK_BYTES - 1);
            end
            state_nxt = S_DIV_CNT;
          end
        end
      end
      S_DIV_CNT: begin
        if (div_done) begin
          count_nxt = div_q;
          state_nxt = S_RANGE;
        end
      end
      S_RANGE: begin
        if (nonempty) begin
          map_cmd   = '{start: 1'b1, op: MAP_FILL, set: (act_r == ACT_RESERVE)};
          state_nxt = S_MAP;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_MAP: begin
        if (map_rsp.done) begin
          if (act_r == ACT_ALLOC) begin
            frame_nxt = map_frame;
            oom_nxt   = map_rsp.oom;
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_MUL: begin
        if (!oom_r) begin
          addr_nxt = ADDR_W'(frame_r) * ADDR_W'(BLOCK_BYTES);
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // output register frees up in the same cycle it is taken
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = '{frame_address: addr_r, out_of_memory: oom_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    size_r     <= size_nxt;
    first_r    <= first_nxt;
    count_r    <= count_nxt;
    frame_r    <= frame_nxt;
    oom_r      <= oom_nxt;
    addr_r     <= addr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_oom_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.out_of_memory && (out_data.frame_address != '0)))
    else $error("out_of_memory with nonzero address");

  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_RESP))
    else $error("output word loaded outside response state");

  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> ((state_r == S_DIV_BASE) || (state_r == S_DIV_CNT)))
    else $error("divider finished with nobody waiting");
`endif

endmodule

// ===== sim/frame_bitmap_allocator_unit_test.sv =====
// Checks frame_bitmap_allocator_unit against a behavioral bitmap kept in the
// bench. A directed table comes first, then a long random mix of release,
// reserve, alloc and free words aimed at the low frames so the map fragments.
// Both handshakes idle at random. One long output hold makes the block back up
// and stall its input, and one pause lets the block drain fully.
module frame_bitmap_allocator_unit_test;
  import fbm_pkg::*;

  localparam int unsigned NUM_FRAMES     = 4096;
  localparam int unsigned BLOCK_BYTES    = 4096;
  localparam int unsigned HALF_PERIOD    = 6;
  localparam int unsigned RESET_CYCLES   = 9;
  localparam int unsigned RANDOM_WORDS   = 600;
  localparam int unsigned HOT_FRAMES     = 128;   // most traffic lands in words 0..1
  localparam int unsigned HOLD_AT        = 200;   // random word that starts the long hold
  localparam int unsigned HOLD_CYCLES    = 500;
  localparam int unsigned DRAIN_AT       = 400;   // random word that waits for an empty pipe
  localparam int unsigned SETTLE_CYCLES  = 200;
  localparam int unsigned TIMEOUT_CYCLES = 800000;
  localparam int unsigned MAX_PRINTS     = 40;
  localparam logic [SIZE_W-1:0] WHOLE_MAP = 25'h100_0000;  // 2^24 bytes, the whole map

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  fba_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  fba_out_t out_data;

  frame_bitmap_allocator_unit #(
    .NUM_FRAMES (NUM_FRAMES),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------
  // Bench copy of the frame bitmap and the result words still owed
  // ---------------------------------------------------------------------
  bit          frame_busy [NUM_FRAMES];
  fba_out_t    grant_queue [$];
  int unsigned mismatch_count = 0;

  // Shared knobs between the sender and the receiver.
  bit steady_phase  = 1'b0;  // no new idle spells on either side while set
  bit hold_request  = 1'b0;  // receiver takes one long hold when set

  task automatic flag_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // Write val to blocks [first_blk, first_blk+count), clipped at the map end.
  function automatic void mark_blocks(longint unsigned first_blk, longint unsigned count,
                                      bit val);
    longint unsigned stop;
    if (first_blk >= NUM_FRAMES)
      return;
    stop = first_blk + count;
    if (stop > NUM_FRAMES)
      stop = NUM_FRAMES;
    for (longint unsigned i = first_blk; i < stop; i++)
      frame_busy[i] = val;
  endfunction

  // Apply one request word to the bench map and return the result word owed.
  function automatic fba_out_t next_allocator_result(fba_in_t req);
    fba_out_t        res;
    longint unsigned first_blk;
    longint unsigned offs;
    longint unsigned span;
    longint unsigned byte_addr;
    int              hit;
    res       = '0;
    first_blk = req.base_address / BLOCK_BYTES;
    offs      = req.base_address % BLOCK_BYTES;
    case (action_t'(req.action))
      ACT_RELEASE: begin
        // whole blocks only; a trailing partial block stays as it was
        mark_blocks(first_blk, req.region_size / BLOCK_BYTES, 1'b0);
        frame_busy[0] = 1'b1;
      end
      ACT_RESERVE: begin
        // every block touched, so an unaligned empty region still takes one
        span = offs + req.region_size;
        mark_blocks(first_blk, (span + BLOCK_BYTES - 1) / BLOCK_BYTES, 1'b1);
      end
      ACT_ALLOC: begin
        // frame 0 is never handed out, even when clear
        hit = -1;
        for (int f = 1; f < NUM_FRAMES; f++) begin
          if (!frame_busy[f]) begin
            hit = f;
            break;
          end
        end
        if (hit < 0) begin
          res.out_of_memory = 1'b1;
        end else begin
          frame_busy[hit]   = 1'b1;
          byte_addr         = longint'(hit) * BLOCK_BYTES;
          res.frame_address = byte_addr[ADDR_W-1:0];
        end
      end
      default: begin
        if (first_blk < NUM_FRAMES)
          frame_busy[first_blk] = 1'b0;
      end
    endcase
    return res;
  endfunction

  // Idle length: mostly short, sometimes medium, rarely long.
  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75)
      return $urandom_range(1, 3);
    else if (r < 95)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random request word. Bases cluster on the low frames so alloc, free and
  // region words keep hitting the same part of the map; a few words use the
  // full field ranges and a few big regions refill or empty the map.
  function automatic fba_in_t random_request();
    fba_in_t         req;
    int unsigned     pick;
    int unsigned     frame_no;
    int unsigned     odds;
    bit [31:0]       raw;
    longint unsigned byte_addr;
    longint unsigned size_val;
    pick     = $urandom_range(0, 99);
    odds     = $urandom_range(0, 99);
    frame_no = ($urandom_range(0, 4) == 0) ? $urandom_range(0, NUM_FRAMES - 1)
                                           : $urandom_range(0, HOT_FRAMES - 1);
    byte_addr = longint'(frame_no) * BLOCK_BYTES;
    if ($urandom_range(0, 1) == 1)
      byte_addr += $urandom_range(0, BLOCK_BYTES - 1);
    req.base_address = byte_addr[ADDR_W-1:0];
    if ($urandom_range(0, 19) == 0) begin
      raw              = $urandom;
      req.base_address = raw[ADDR_W-1:0];
    end
    size_val = longint'($urandom_range(0, 16)) * BLOCK_BYTES;
    if ($urandom_range(0, 1) == 1)
      size_val += $urandom_range(0, BLOCK_BYTES - 1);
    if (pick < 35) begin
      req.action = ACT_ALLOC;
      size_val   = $urandom_range(0, WHOLE_MAP);
    end else if (pick < 60) begin
      req.action = ACT_FREE;
      size_val   = $urandom_range(0, WHOLE_MAP);
    end else if (pick < 80) begin
      req.action = ACT_RELEASE;
      if (odds < 10)
        size_val = $urandom_range(0, WHOLE_MAP);
      else if (odds < 14)
        size_val = WHOLE_MAP;
    end else begin
      req.action = ACT_RESERVE;
      if (odds < 3)
        size_val = $urandom_range(0, WHOLE_MAP);
      else if (odds < 4)
        size_val = WHOLE_MAP;
    end
    req.region_size = size_val[SIZE_W-1:0];
    return req;
  endfunction

  // ---------------------------------------------------------------------
  // Directed table. Rows with a typed result push that word instead of the
  // bench prediction; the bench map is updated for every row either way.
  // ---------------------------------------------------------------------
  typedef struct {
    action_t           act;
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
    bit                typed;
    logic [ADDR_W-1:0] grant;
    bit                no_frame;
  } directed_row_t;

  localparam int unsigned DIRECTED_ROWS = 24;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // map is all used out of reset: alloc fails
    '{ACT_ALLOC,   24'h000000, 25'h0000000, 1'b1, 24'h000000, 1'b1},
    // free the top frame through the highest address, then hand it out
    '{ACT_FREE,    24'hFFFFFF, 25'h0000000, 1'b1, 24'h000000, 1'b0},
    '{ACT_ALLOC,   24'h000000, 25'h1FFFFFF, 1'b1, 24'hFFF000, 1'b0},
    '{ACT_ALLOC,   24'h000000, 25'h0000000, 1'b1, 24'h000000, 1'b1},
    // release the whole map; frame 0 comes back used
    '{ACT_RELEASE, 24'h000000, WHOLE_MAP,   1'b1, 24'h000000, 1'b0},
    '{ACT_ALLOC,   24'h000000, 25'h0000000, 1'b1, 24'h001000, 1'b0},
    // clear frame 0 by free; alloc still skips it
    '{ACT_FREE,    24'h000ABC, 25'h0000000, 1'b0, 24'h000000, 1'b0},
    '{ACT_ALLOC,   24'h000000, 25'h0000000, 1'b0, 24'h000000, 1'b0},
    // empty reserve: unaligned base still takes its block, aligned takes none
    '{ACT_RESERVE, 24'h000FFF, 25'h0000000, 1'b0, 24'h000000, 1'b0},
    '{ACT_RESERVE, 24'h003000, 25'h0000000, 1'b0, 24'h000000, 1'b0},
    '{ACT_ALLOC,   24'h000000, 25'h0000000, 1'b0, 24'h000000, 1'b0},
    // unaligned reserve of one block's length spans two blocks
    '{ACT_RESERVE, 24'h004800, 25'h0001000, 1'b0, 24'h000000, 1'b0},
    '{ACT_ALLOC,   24'h000000, 25'h0000000, 1'b0, 24'h000000, 1'b0},
    // release keeps only whole blocks of the size
    '{ACT_RELEASE, 24'h005FFF, 25'h0001FFF, 1'b0, 24'h000000, 1'b0},
    '{ACT_ALLOC,   24'h000000, 25'h0000000, 1'b0, 24'h000000, 1'b0},
    // empty release only marks frame 0
    '{ACT_RELEASE, 24'h000000, 25'h0000000, 1'b0, 24'h000000, 1'b0},
    // reserves clipped at the map end, then a full map
    '{ACT_RESERVE, 24'hFFFFFF, WHOLE_MAP,   1'b1, 24'h000000, 1'b0},
    '{ACT_RESERVE, 24'h000000, WHOLE_MAP,   1'b1, 24'h000000, 1'b0},
    '{ACT_ALLOC,   24'hFFFFFF, 25'h1FFFFFF, 1'b1, 24'h000000, 1'b1},
    // release of the top half, clipped
    '{ACT_RELEASE, 24'h800000, WHOLE_MAP,   1'b1, 24'h000000, 1'b0},
    '{ACT_ALLOC,   24'h000000, 25'h0000000, 1'b1, 24'h800000, 1'b0},
    '{ACT_FREE,    24'h555555, 25'h0AAAAAA, 1'b0, 24'h000000, 1'b0},
    '{ACT_ALLOC,   24'h000000, 25'h0000000, 1'b0, 24'h000000, 1'b0},
    '{ACT_RELEASE, 24'hAAAAAA, 25'h0FFFFFF, 1'b0, 24'h000000, 1'b0}
  };

  // ---------------------------------------------------------------------
  // Sender side. Valid goes high with the word and stays up until taken;
  // in_ready is sampled at the edge, so it holds the value the DUT used.
  // ---------------------------------------------------------------------
  task automatic send_request(fba_in_t req, bit typed, fba_out_t typed_res);
    fba_out_t predicted;
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predicted = next_allocator_result(req);
    grant_queue.push_back(typed ? typed_res : predicted);
  endtask

  // Gap after an accepted word; valid only drops when there is a gap.
  task automatic sender_gap();
    int unsigned gap;
    gap = 0;
    if (!steady_phase && $urandom_range(0, 2) == 0)
      gap = idle_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    fba_in_t  req;
    fba_out_t typed_res;
    for (int i = 0; i < NUM_FRAMES; i++)
      frame_busy[i] = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    // in_ready stays low through the clearing pass; the handshake covers it

    foreach (directed_rows[r]) begin
      req.action                = directed_rows[r].act;
      req.base_address          = directed_rows[r].base;
      req.region_size           = directed_rows[r].size;
      typed_res.frame_address   = directed_rows[r].grant;
      typed_res.out_of_memory   = directed_rows[r].no_frame;
      send_request(req, directed_rows[r].typed, typed_res);
      sender_gap();
    end

    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      // no new idle spells for a few stretches; the second one overlaps the long hold
      steady_phase = (n >= 100 && n < 150) || (n >= HOLD_AT && n < HOLD_AT + 60)
                  || (n >= 500 && n < 540);
      if (n == HOLD_AT)
        hold_request = 1'b1;
      send_request(random_request(), 1'b0, '0);
      if (n == DRAIN_AT) begin
        // let everything owed come back before the next word
        in_valid <= 1'b0;
        while (grant_queue.size() != 0) @(posedge clk);
      end else begin
        sender_gap();
      end
    end
    in_valid <= 1'b0;

    while (grant_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && grant_queue.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver side: random stalls, plus one long hold on request so the
  // block fills up behind its output word.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned ready_stall;
    ready_stall = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready   <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (ready_stall != 0) begin
        out_ready   <= 1'b0;
        ready_stall--;
      end else begin
        out_ready <= 1'b1;
        if (!steady_phase && $urandom_range(0, 3) == 0)
          ready_stall = idle_cycles();
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result check: each accepted output word against the oldest owed word.
  // ---------------------------------------------------------------------
  fba_out_t due_word;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (grant_queue.size() == 0) begin
        flag_mismatch($sformatf("unexpected word addr=%h oom=%b",
                                out_data.frame_address, out_data.out_of_memory));
      end else begin
        due_word = grant_queue.pop_front();
        if (out_data.frame_address !== due_word.frame_address)
          flag_mismatch($sformatf("frame_address %h, expected %h",
                                  out_data.frame_address, due_word.frame_address));
        if (out_data.out_of_memory !== due_word.out_of_memory)
          flag_mismatch($sformatf("out_of_memory %b, expected %b",
                                  out_data.out_of_memory, due_word.out_of_memory));
      end
    end
  end

  // Hang guard.
  initial begin
    #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
    $display("simulation failed");
    $finish;
  end

endmodule
